[rtl/core/fga_pkg.sv]
// Package for the frame group averager.
// Holds field widths, register indexes and the controller state type.
// No dependencies.
package fga_pkg;

  localparam int SMP_W   = 16;
  localparam int AVG_W   = 24;
  localparam int FRAC_W  = 8;
  localparam int FPA_W   = 11;
  localparam int FPIX_W  = 17;
  localparam int CFG_W   = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_AVG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS   = 1'b1;

  localparam logic [FPA_W-1:0]  FPA_RESET  = 11'd1;
  localparam logic [FPIX_W-1:0] FPIX_RESET = 17'd65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_OUT
  } fga_state_e;

endpackage

[rtl/core/fga_ram.sv]
// Generic simple dual-port RAM, one write and one read port.
// Read data is registered. No dependencies.
module fga_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 65536
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/fga_div.sv]
// Serial signed divider: (magnitude << FRAC_W) / divisor, one quotient bit per cycle.
// Gives the low AVG_W bits of the quotient with the sign applied. Uses fga_pkg.
module fga_div
  import fga_pkg::*;
#(
  parameter int MAG_W = 27
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             neg_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [FPA_W-1:0] divisor_i,
  output logic             done_o,
  output logic [AVG_W-1:0] quot_o
);

  localparam int DW    = MAG_W + FRAC_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic             neg_q, neg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]    dq_q, dq_d;
  logic [FPA_W-1:0] rem_q, rem_d;
  logic [FPA_W-1:0] dvs_q, dvs_d;
  logic [FPA_W:0]   trial;
  logic [FPA_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, dq_q[DW-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      neg_d  = neg_i;
      cnt_d  = CNT_W'(DW);
      dq_d   = {mag_i, {FRAC_W{1'b0}}};
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      dq_d  = {dq_q[DW-2:0], ge};
      rem_d = ge ? diff[FPA_W-1:0] : trial[FPA_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (AVG_W'(0) - dq_q[AVG_W-1:0]) : dq_q[AVG_W-1:0];

endmodule

[rtl/core/frame_group_averager_top.sv]
// Frame group averager top level: accumulator store, position counters, control.
// Uses fga_pkg, fga_ram and fga_div.
//
// Pixel samples come in raster order. A group of frames_per_average frames is summed
// per pixel in one accumulator RAM; on each pixel of the group's last frame the block
// emits sum * 256 / group size (signed Q15.8, truncated toward zero), with frame_last
// on the frame's final pixel. Items are handled one at a time. An item that does not
// belong to the last frame of a group is accepted while its sum is read, then added
// and written back through the accumulator RAM's registered read port. An item of the
// last frame then runs the serial divider, one quotient bit per cycle over SUM_W + 8
// dividend bits, and its result is loaded into the output register once that is free.
// The output register lets a result wait while the next item is taken in. The store
// needs no clearing pass after reset: the first frame of each group overwrites it.
module frame_group_averager_top
  import fga_pkg::*;
#(
  parameter int MAX_PIXELS = 65536,
  parameter int MAX_GROUP  = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [SMP_W-1:0]     sample_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [AVG_W-1:0]     average_o,
  output logic                 frame_last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int NCAP  = MAX_GROUP < 2047 ? MAX_GROUP : 2047;
  localparam int FIG_W = NCAP > 1 ? $clog2(NCAP) : 1;
  localparam int SUM_W = SMP_W + 1 + $clog2(NCAP);
  localparam int POS_W = MAX_PIXELS > 1 ? $clog2(MAX_PIXELS) : 1;
  localparam int LW0   = $clog2(MAX_PIXELS + 1);
  localparam int LEN_W = LW0 > FPIX_W ? LW0 : FPIX_W;

  localparam logic [FPA_W-1:0] NCAP_V  = FPA_W'(NCAP);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PIXELS);

  fga_state_e state_q, state_d;

  logic [FPA_W-1:0]  fpa_q;
  logic [FPIX_W-1:0] fpix_q;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [FIG_W-1:0]  fig_q, fig_d;

  logic [SMP_W-1:0]  smp_q;
  logic [POS_W-1:0]  idx_q;
  logic              first_q;
  logic              last_pixel_q;
  logic              last_frame_q;

  logic              out_valid_q;
  logic [AVG_W-1:0]  average_q;
  logic              frame_last_q;

  logic [FPA_W-1:0]  grp_n;
  logic [LEN_W-1:0]  frm_len;
  logic              last_pixel_w;
  logic              last_frame_w;
  logic              in_acc;
  logic              ram_we;
  logic              div_start;
  logic              out_load;
  logic [SUM_W-1:0]  rdata;
  logic [SUM_W-1:0]  smp_ext;
  logic [SUM_W-1:0]  sum_w;
  logic [SUM_W-1:0]  mag_w;
  logic              div_done;
  logic [AVG_W-1:0]  quot;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fpa_q  <= FPA_RESET;
      fpix_q <= FPIX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAMES_PER_AVG: fpa_q  <= cfg_data_i[FPA_W-1:0];
        CFG_FRAME_PIXELS:   fpix_q <= cfg_data_i[FPIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fpa_q == '0) begin
      grp_n = FPA_W'(1);
    end else if (fpa_q > NCAP_V) begin
      grp_n = NCAP_V;
    end else begin
      grp_n = fpa_q;
    end
  end

  always_comb begin
    if (fpix_q == '0 || LEN_W'(fpix_q) > LEN_MAX) begin
      frm_len = LEN_MAX;
    end else begin
      frm_len = LEN_W'(fpix_q);
    end
  end

  assign last_pixel_w = (LEN_W'(pos_q) + LEN_W'(1)) >= frm_len;
  assign last_frame_w = ({1'b0, FPA_W'(fig_q)} + (FPA_W + 1)'(1)) >= {1'b0, grp_n};

  assign in_acc = in_valid_i && !in_stall_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RMW;
      ST_RMW:  state_d = last_frame_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o = 1'b1;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: in_stall_o = 1'b0;
      ST_RMW: begin
        ram_we    = 1'b1;
        div_start = last_frame_q;
      end
      ST_DIV: ;
      ST_OUT:  out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  // Position and frame counters advance at accept
  always_comb begin
    pos_d = pos_q;
    fig_d = fig_q;
    if (in_acc) begin
      if (last_pixel_w) begin
        pos_d = '0;
        fig_d = last_frame_w ? '0 : fig_q + FIG_W'(1);
      end else begin
        pos_d = pos_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      fig_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fig_q   <= fig_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q        <= sample_i;
      idx_q        <= pos_q;
      first_q      <= fig_q == '0;
      last_pixel_q <= last_pixel_w;
      last_frame_q <= last_frame_w;
    end
    if (out_load) begin
      average_q    <= quot;
      frame_last_q <= last_pixel_q;
    end
  end

  assign smp_ext = {{(SUM_W - SMP_W){smp_q[SMP_W-1]}}, smp_q};
  assign sum_w   = first_q ? smp_ext : rdata + smp_ext;
  assign mag_w   = sum_w[SUM_W-1] ? (~sum_w + SUM_W'(1)) : sum_w;

  fga_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_PIXELS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (sum_w),
    .re_i    (in_acc),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  fga_div #(
    .MAG_W (SUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .neg_i     (sum_w[SUM_W-1]),
    .mag_i     (mag_w),
    .divisor_i (grp_n),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign out_valid_o  = out_valid_q;
  assign average_o    = average_q;
  assign frame_last_o = frame_last_q;

  a_accept_to_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_RMW)
    else $error("accepted item did not enter read-modify-write");

  a_last_frame_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RMW && last_frame_q |=> state_q == ST_DIV)
    else $error("last-frame item skipped the divider");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

endmodule
